FILE: rtl/cmap_pkg.sv
// cmap_pkg: shared types and constants for the segment-mapped glyph lookup
// word structs, action and status codes, store dimensions
// no dependencies
`timescale 1ns / 1ps

package cmap_pkg;

  localparam int MAX_SEGMENTS      = 256;
  localparam int GLYPH_ARRAY_WORDS = 4096;
  localparam int SEG_AW            = $clog2(MAX_SEGMENTS);
  localparam int GLY_AW            = $clog2(GLYPH_ARRAY_WORDS);
  localparam int CNT_W             = 9;
  localparam int SUM_W             = 18;

  localparam logic [1:0] ACT_LOAD_SEG   = 2'd0;
  localparam logic [1:0] ACT_LOAD_GLYPH = 2'd1;
  localparam logic [1:0] ACT_LOOKUP     = 2'd2;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_NO_SEG = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] index;
    logic [15:0] start_code;
    logic [15:0] end_code;
    logic [15:0] id_delta;
    logic [15:0] range_offset;
    logic [15:0] array_word;
    logic [15:0] character;
  } in_word_t;

  typedef struct packed {
    logic [15:0] glyph_id;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [15:0] start_code;
    logic [15:0] end_code;
    logic [15:0] id_delta;
    logic [15:0] range_offset;
  } seg_entry_t;

endpackage

FILE: rtl/cmap_ram.sv
// cmap_ram: generic single-write, single-read memory with registered read
// no dependencies
`timescale 1ns / 1ps

module cmap_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cmap_segment_glyph_lookup.sv
// cmap_segment_glyph_lookup: segment-mapped character to glyph lookup, top level
// depends on cmap_pkg and cmap_ram (segment table and glyph array memories)
`timescale 1ns / 1ps

//  channel | ports                          | moves
//  --------+--------------------------------+---------------------------------
//  in      | in_valid, in_ready, in_word    | load segment, load glyph, lookup
//  out     | out_valid, out_ready, out_word | glyph id and status per lookup
//  cfg     | cfg_we, cfg_wdata              | seg_count, written without wait
//
//  a load word is written into its memory at acceptance; a lookup runs a linear
//  segment scan through the segment memory, one entry read per cycle
//  rst_n is synchronous; memories hold no reset; the user must read them only
//  after load, which the block does not enforce
//  a finished result sits in the output register; a new word is taken
//  while it waits, and a lookup that completes before it drains holds

module cmap_segment_glyph_lookup (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cmap_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cmap_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_wdata
);

  import cmap_pkg::*;

  // lookup sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_GREAD = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  seg_count_r;
  logic [CNT_W-1:0]  count_r, count_nxt;       // clamped segment count
  logic [CNT_W-1:0]  issue_r, issue_nxt;       // next segment to read
  logic [CNT_W-1:0]  chk_idx_r, chk_idx_nxt;   // segment in the read register
  logic              chk_valid_r, chk_valid_nxt;
  logic [15:0]       char_r, char_nxt;
  seg_entry_t        hit_r, hit_nxt;
  logic [CNT_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [15:0]       res_glyph_r, res_glyph_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              in_acc;
  logic [CNT_W-1:0]  count_clamp;
  logic              seg_we;
  logic              gly_we;
  seg_entry_t        seg_wdata;
  seg_entry_t        seg_rdata;
  logic [SEG_AW-1:0] seg_raddr;
  logic [15:0]       gly_rdata;
  logic [GLY_AW-1:0] gly_raddr;
  logic              seg_hit;
  logic              scan_last;
  logic [SUM_W-1:0]  pos_sum;
  logic [SUM_W-1:0]  pos_diff;
  logic              pos_bad;
  logic              out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // seg_count beyond the table depth scans the whole table
  assign count_clamp = (seg_count_r > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                            : seg_count_r;

  // loads beyond the store depth are dropped
  assign seg_we = in_acc && (in_word.action == ACT_LOAD_SEG)
                  && ({1'b0, in_word.index} < 13'(MAX_SEGMENTS));
  assign gly_we = in_acc && (in_word.action == ACT_LOAD_GLYPH)
                  && ({1'b0, in_word.index} < 13'(GLYPH_ARRAY_WORDS));

  assign seg_wdata.start_code   = in_word.start_code;
  assign seg_wdata.end_code     = in_word.end_code;
  assign seg_wdata.id_delta     = in_word.id_delta;
  assign seg_wdata.range_offset = in_word.range_offset;

  assign seg_raddr = issue_r[SEG_AW-1:0];

  cmap_ram #(
    .WIDTH ($bits(seg_entry_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (in_word.index[SEG_AW-1:0]),
    .wdata (seg_wdata),
    .raddr (seg_raddr),
    .rdata (seg_rdata)
  );

  cmap_ram #(
    .WIDTH (16),
    .DEPTH (GLYPH_ARRAY_WORDS)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (gly_we),
    .waddr (in_word.index[GLY_AW-1:0]),
    .wdata (in_word.array_word),
    .raddr (gly_raddr),
    .rdata (gly_rdata)
  );

  // compare the segment that came back from the memory this cycle
  assign seg_hit   = (char_r >= seg_rdata.start_code) && (char_r <= seg_rdata.end_code);
  assign scan_last = (chk_idx_r + CNT_W'(1)) == count_r;

  // glyph array position: seg + offset/2 + (char - start) - count
  assign pos_sum  = SUM_W'(hit_idx_r) + SUM_W'(hit_r.range_offset[15:1])
                  + SUM_W'(char_r - hit_r.start_code);
  assign pos_diff = pos_sum - SUM_W'(count_r);
  assign pos_bad  = (pos_sum < SUM_W'(count_r))
                  || (pos_diff >= SUM_W'(GLYPH_ARRAY_WORDS));
  assign gly_raddr = pos_diff[GLY_AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    chk_idx_nxt    = chk_idx_r;
    chk_valid_nxt  = 1'b0;
    char_nxt       = char_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    res_glyph_nxt  = res_glyph_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_word_nxt   = out_word_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_word.action == ACT_LOOKUP)) begin
          char_nxt  = in_word.character;
          count_nxt = count_clamp;
          issue_nxt = '0;
          if (count_clamp == '0) begin
            // empty table: nothing can hold the character
            res_glyph_nxt  = '0;
            res_status_nxt = ST_NO_SEG;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one read issued per cycle, checked the cycle after
        if (issue_r < count_r) begin
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = issue_r;
          issue_nxt     = issue_r + CNT_W'(1);
        end
        if (chk_valid_r && seg_hit) begin
          hit_nxt       = seg_rdata;
          hit_idx_nxt   = chk_idx_r;
          chk_valid_nxt = 1'b0;
          state_nxt     = S_CALC;
        end else if (chk_valid_r && scan_last) begin
          res_glyph_nxt  = '0;
          res_status_nxt = ST_NO_SEG;
          chk_valid_nxt  = 1'b0;
          state_nxt      = S_DONE;
        end
      end
      S_CALC: begin
        if (hit_r.range_offset == '0) begin
          res_glyph_nxt  = hit_r.id_delta + char_r;
          res_status_nxt = ST_FOUND;
          state_nxt      = S_DONE;
        end else if (pos_bad) begin
          res_glyph_nxt  = '0;
          res_status_nxt = ST_RANGE;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_GREAD;
        end
      end
      S_GREAD: begin
        // a zero array word maps to glyph 0 without the delta
        res_glyph_nxt  = (gly_rdata == '0) ? 16'd0 : gly_rdata + hit_r.id_delta;
        res_status_nxt = ST_FOUND;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_word_nxt.glyph_id = res_glyph_r;
          out_word_nxt.status   = res_status_r;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seg_count_r <= CNT_W'(1);
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_valid_r <= chk_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        seg_count_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    count_r      <= count_nxt;
    issue_r      <= issue_nxt;
    chk_idx_r    <= chk_idx_nxt;
    char_r       <= char_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    res_glyph_r  <= res_glyph_nxt;
    res_status_r <= res_status_nxt;
    out_word_r   <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  // a miss or range error always carries glyph 0
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.status == ST_FOUND) || (out_word.glyph_id == 16'd0))
    else $error("nonzero glyph with failing status");

  // the scan never checks past the clamped segment count
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && chk_valid_r |-> (chk_idx_r < count_r))
    else $error("segment scan ran past seg_count");

  // a lookup word blocks the input until its result is queued
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_word.action == ACT_LOOKUP) |=> !in_ready)
    else $error("input accepted during lookup");

  // a glyph array read only follows an in-range position
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GREAD) |-> $past(!pos_bad) && (hit_r.range_offset != '0))
    else $error("glyph array read with bad position");
`endif

endmodule

FILE: tb/cmap_segment_glyph_lookup_test.sv
// cmap_segment_glyph_lookup_test: self-checking bench for the segment-mapped glyph lookup
// drives load and lookup words, predicts or types in every lookup result, checks them in order
// depends on cmap_pkg and the cmap_segment_glyph_lookup top level
`timescale 1ns / 1ps

module cmap_segment_glyph_lookup_test;
  import cmap_pkg::*;

  localparam int HALF_HIGH      = 6;
  localparam int HALF_LOW       = 6;
  localparam int RESET_CYCLES   = 10;
  // settle past the longest lookup, a scan of the full segment table
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASES         = 9;

  // one expected lookup result plus the character that caused it
  typedef struct packed {
    out_word_t   word;
    logic [15:0] ch;
  } pending_t;

  // one row of the directed table: a register write or a word
  typedef struct {
    bit          is_cfg;
    logic [8:0]  cfg_value;
    in_word_t    word;
    bit          typed;
    out_word_t   want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;

  // receiver control; ready_idle_pct and hold_start written by the main process with nonblocking assignments
  int          ready_idle_pct = 0;
  logic        hold_start = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;

  int          send_idle_pct = 0;
  int          fail_count = 0;
  int          quiet_cycles = 0;

  // predictor copy of the block state
  logic [15:0] seg_starts  [MAX_SEGMENTS];
  logic [15:0] seg_ends    [MAX_SEGMENTS];
  logic [15:0] seg_deltas  [MAX_SEGMENTS];
  logic [15:0] seg_offsets [MAX_SEGMENTS];
  bit          seg_loaded  [MAX_SEGMENTS];
  logic [15:0] glyph_words [GLYPH_ARRAY_WORDS];
  bit          glyph_loaded[GLYPH_ARRAY_WORDS];
  logic [8:0]  seg_count_r;

  pending_t    pending_glyphs[$];
  dir_row_t    directed_rows[$];

  // segment and glyph fills ahead of lookups add words on top of these
  logic [8:0]  phase_segs [PHASES] = '{9'd3, 9'd16, 9'd1, 9'd256, 9'd0, 9'd8, 9'd511, 9'd5, 9'd64};
  int          phase_items[PHASES] = '{100, 100, 70, 30, 30, 100, 20, 80, 40};

  cmap_segment_glyph_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #HALF_HIGH clk = 1'b1;
    #HALF_LOW  clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // segments actually searched: counts past the table depth use the whole table
  function automatic int active_segments();
    return (seg_count_r > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count_r);
  endfunction

  // first-hit segment search, then direct delta or glyph array read;
  // array_pos tells which glyph word gets read, -1 when none
  function automatic pending_t map_character(input logic [15:0] ch, output int array_pos);
    int          count;
    int          s;
    int          hit;
    int          pos;
    logic [15:0] word;
    pending_t    r;
    r.ch      = ch;
    r.word    = '0;
    array_pos = -1;
    hit       = -1;
    count     = active_segments();
    for (s = 0; s < count && hit < 0; s++)
      if (ch >= seg_starts[s] && ch <= seg_ends[s]) hit = s;
    if (hit < 0) begin
      r.word.status = ST_NO_SEG;
    end else if (seg_offsets[hit] == 16'd0) begin
      r.word.glyph_id = seg_deltas[hit] + ch;
      r.word.status   = ST_FOUND;
    end else begin
      pos = hit + int'(seg_offsets[hit] >> 1) + (int'(ch) - int'(seg_starts[hit])) - count;
      if (pos < 0 || pos >= GLYPH_ARRAY_WORDS) begin
        r.word.status = ST_RANGE;
      end else begin
        array_pos = pos;
        word      = glyph_words[pos];
        // a zero array word means glyph 0, delta not applied
        if (word != 16'd0) word = word + seg_deltas[hit];
        r.word.glyph_id = word;
        r.word.status   = ST_FOUND;
      end
    end
    return r;
  endfunction

  // apply one accepted word to the predictor state, queue a lookup's result
  function automatic void accept_word(input in_word_t w, input bit typed, input out_word_t want);
    int       pos;
    pending_t r;
    case (w.action)
      ACT_LOAD_SEG: begin
        // segment loads past the table depth are dropped
        if (w.index < MAX_SEGMENTS) begin
          seg_starts[w.index]  = w.start_code;
          seg_ends[w.index]    = w.end_code;
          seg_deltas[w.index]  = w.id_delta;
          seg_offsets[w.index] = w.range_offset;
          seg_loaded[w.index]  = 1'b1;
        end
      end
      ACT_LOAD_GLYPH: begin
        if (w.index < GLYPH_ARRAY_WORDS) begin
          glyph_words[w.index]  = w.array_word;
          glyph_loaded[w.index] = 1'b1;
        end
      end
      ACT_LOOKUP: begin
        r = map_character(w.character, pos);
        if (typed) r.word = want;
        pending_glyphs.push_back(r);
      end
      default: ;  // unused action: no effect, no result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_failure(input string msg);
    if (fail_count < REPORT_LIMIT) $display("%s", msg);
    fail_count++;
  endtask

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    pending_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_glyphs.size() == 0) begin
        note_failure($sformatf("unexpected result word: glyph %h status %0d",
                               out_word.glyph_id, out_word.status));
      end else begin
        want = pending_glyphs.pop_front();
        if (out_word.glyph_id !== want.word.glyph_id || out_word.status !== want.word.status)
          note_failure($sformatf("char %h: expected glyph %h status %0d, got glyph %h status %0d",
                                 want.ch, want.word.glyph_id, want.word.status,
                                 out_word.glyph_id, out_word.status));
      end
    end
  end

  // watchdog: cycles in which neither channel moves a word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("cmap_segment_glyph_lookup regression: fail");
      $finish;
    end
  end

  // receiver: random idling, plus one long hold-off that it counts itself
  always @(posedge clk) begin
    if (hold_start && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= ready_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offer one word, with a random gap first; valid stays high across back-to-back words
  task automatic send_word(input in_word_t w, input bit typed = 1'b0,
                           input out_word_t want = '0);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    accept_word(w, typed, want);
  endtask

  // sender pause: drop valid and wait for every expected result
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
  endtask

  // register writes only on an idle block; loads leave no result, so settle too
  task automatic write_seg_count(input logic [8:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seg_count_r = value;
  endtask

  // all fields random so that unused fields toggle too
  function automatic in_word_t noise_word();
    in_word_t w;
    w.action       = 2'($urandom);
    w.index        = 12'($urandom);
    w.start_code   = 16'($urandom);
    w.end_code     = 16'($urandom);
    w.id_delta     = 16'($urandom);
    w.range_offset = 16'($urandom);
    w.array_word   = 16'($urandom);
    w.character    = 16'($urandom);
    return w;
  endfunction

  // segment with a short range mostly; offsets either zero, aimed inside the
  // glyph array, or random (usually out of range)
  function automatic in_word_t random_segment(input int s);
    in_word_t w;
    int       span;
    w        = noise_word();
    w.action = ACT_LOAD_SEG;
    w.index  = 12'(s);
    case ($urandom_range(9))
      0: begin
        w.start_code = 16'h0000;
        w.end_code   = 16'hffff;
      end
      1: w.end_code = w.start_code - 16'd1;  // empty segment, or the full range at zero
      default: begin
        span = $urandom_range(40);
        w.end_code = (int'(w.start_code) + span > 65535) ? 16'hffff : w.start_code + 16'(span);
      end
    endcase
    case ($urandom_range(3))
      0, 1: w.range_offset = 16'd0;
      2: w.range_offset = 16'(2 * (active_segments() - s + $urandom_range(200))
                              + $urandom_range(1));
      default: ;
    endcase
    return w;
  endfunction

  function automatic in_word_t glyph_load(input int pos);
    in_word_t w;
    w            = noise_word();
    w.action     = ACT_LOAD_GLYPH;
    w.index      = 12'(pos);
    if ($urandom_range(7) == 0) w.array_word = 16'd0;
    return w;
  endfunction

  // a lookup never touches unwritten entries: fill the searched segments and
  // the one glyph word it will read before offering it
  task automatic send_lookup();
    int          n;
    int          s;
    int          pos;
    logic [15:0] ch;
    in_word_t    w;
    pending_t    r;
    n = active_segments();
    for (s = 0; s < n; s++)
      if (!seg_loaded[s]) send_word(random_segment(s));
    ch = 16'($urandom);
    if (n > 0 && $urandom_range(9) < 7) begin
      s = $urandom_range(n - 1);
      if (seg_ends[s] >= seg_starts[s])
        ch = seg_starts[s] + 16'($urandom_range(int'(seg_ends[s] - seg_starts[s])));
    end
    r = map_character(ch, pos);
    if (pos >= 0 && !glyph_loaded[pos]) send_word(glyph_load(pos));
    w           = noise_word();
    w.action    = ACT_LOOKUP;
    w.character = ch;
    send_word(w);
  endtask

  task automatic send_random_item();
    int       pick;
    in_word_t w;
    pick = $urandom_range(99);
    if (pick < 50) begin
      send_lookup();
    end else if (pick < 70) begin
      send_word(random_segment($urandom_range(MAX_SEGMENTS - 1)));
    end else if (pick < 85) begin
      send_word(glyph_load($urandom_range(GLYPH_ARRAY_WORDS - 1)));
    end else if (pick < 93) begin
      // segment load beyond the table: dropped by the block
      w        = noise_word();
      w.action = ACT_LOAD_SEG;
      w.index  = 12'($urandom_range(4095, MAX_SEGMENTS));
      send_word(w);
    end else begin
      w        = noise_word();
      w.action = 2'd3;
      send_word(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------

  function automatic in_word_t seg_word(input logic [11:0] idx, input logic [15:0] first,
                                        input logic [15:0] last, input logic [15:0] delta,
                                        input logic [15:0] offset);
    in_word_t w;
    w = '0;
    w.action       = ACT_LOAD_SEG;
    w.index        = idx;
    w.start_code   = first;
    w.end_code     = last;
    w.id_delta     = delta;
    w.range_offset = offset;
    return w;
  endfunction

  function automatic in_word_t glyph_word(input logic [11:0] idx, input logic [15:0] value);
    in_word_t w;
    w = '0;
    w.action     = ACT_LOAD_GLYPH;
    w.index      = idx;
    w.array_word = value;
    return w;
  endfunction

  function automatic void add_row(input in_word_t w);
    directed_rows.push_back('{1'b0, 9'd0, w, 1'b0, out_word_t'('0)});
  endfunction

  // lookup row with its result typed in
  function automatic void add_check(input logic [15:0] ch, input logic [15:0] glyph,
                                    input logic [1:0] status);
    in_word_t w;
    w           = '0;
    w.action    = ACT_LOOKUP;
    w.character = ch;
    directed_rows.push_back('{1'b0, 9'd0, w, 1'b1, out_word_t'({glyph, status})});
  endfunction

  function automatic void add_cfg(input logic [8:0] value);
    directed_rows.push_back('{1'b1, value, in_word_t'('0), 1'b0, out_word_t'('0)});
  endfunction

  function automatic void build_directed_table();
    // one segment over every code, delta zero: glyph equals the character
    add_row(seg_word(12'd0, 16'h0000, 16'hffff, 16'h0000, 16'h0000));
    add_check(16'hffff, 16'hffff, ST_FOUND);
    add_check(16'h0000, 16'h0000, ST_FOUND);
    // largest delta wraps; codes just outside the bounds miss
    add_row(seg_word(12'd0, 16'h0010, 16'h0020, 16'hffff, 16'h0000));
    add_check(16'h0010, 16'h000f, ST_FOUND);
    add_check(16'h0020, 16'h001f, ST_FOUND);
    add_check(16'h000f, 16'h0000, ST_NO_SEG);
    add_check(16'h0021, 16'h0000, ST_NO_SEG);
    // array read with delta added, and a zero array word
    add_row(seg_word(12'd0, 16'h0100, 16'h01ff, 16'h0005, 16'h0002));
    add_row(glyph_word(12'd0, 16'h1234));
    add_row(glyph_word(12'd1, 16'h0000));
    add_check(16'h0100, 16'h1239, ST_FOUND);
    add_check(16'h0101, 16'h0000, ST_FOUND);
    // largest offset lands past the array end
    add_row(seg_word(12'd0, 16'h0000, 16'hffff, 16'h0000, 16'hfffe));
    add_check(16'h0000, 16'h0000, ST_RANGE);
    // two segments: negative array position, first hit wins on overlap
    add_cfg(9'd2);
    add_row(seg_word(12'd0, 16'h0050, 16'h005f, 16'h0000, 16'h0002));
    add_row(seg_word(12'd1, 16'h0050, 16'h006f, 16'h0007, 16'h0000));
    add_check(16'h0050, 16'h0000, ST_RANGE);
    add_check(16'h0051, 16'h1234, ST_FOUND);
    add_check(16'h0065, 16'h006c, ST_FOUND);
    add_check(16'h0070, 16'h0000, ST_NO_SEG);
    // dropped segment load at the top index, unused action with all ones
    add_row(seg_word(12'hfff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    add_row(in_word_t'({$bits(in_word_t){1'b1}}));
    // last array word, delta wraps a nonzero word to zero, one past the end
    add_row(glyph_word(12'hfff, 16'hffff));
    add_row(seg_word(12'd0, 16'h0050, 16'h005f, 16'h0001, 16'h2002));
    add_check(16'h0050, 16'h0000, ST_FOUND);
    add_check(16'h0051, 16'h0000, ST_RANGE);
    // no segment searched at all
    add_cfg(9'd0);
    add_check(16'h1234, 16'h0000, ST_NO_SEG);
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int p;
    int i;
    for (i = 0; i < MAX_SEGMENTS; i++) seg_loaded[i] = 1'b0;
    for (i = 0; i < GLYPH_ARRAY_WORDS; i++) glyph_loaded[i] = 1'b0;
    seg_count_r = 9'd1;
    build_directed_table();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, no idling on either side
    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg)
        write_seg_count(directed_rows[r].cfg_value);
      else
        send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].want);
    end

    // random part: sender 17 / receiver 78, then swapped, then no idling
    for (p = 0; p < PHASES; p++) begin
      write_seg_count(phase_segs[p]);
      if (p < 3) begin
        send_idle_pct = 17;
        ready_idle_pct <= 78;
      end else if (p < 6) begin
        send_idle_pct = 78;
        ready_idle_pct <= 17;
      end else begin
        send_idle_pct = 0;
        ready_idle_pct <= 0;
      end
      // long receiver hold-off while words keep coming, so the input stalls
      if (p == 5) hold_start <= 1'b1;
      for (i = 0; i < phase_items[p]; i++) begin
        // one mid-phase pause until every result is back
        if (p == 1 && i == 70) wait_drained();
        send_random_item();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_glyphs.size() != 0)
      note_failure($sformatf("%0d expected result words never arrived", pending_glyphs.size()));
    if (fail_count == 0) begin
      $display("cmap_segment_glyph_lookup regression: pass");
    end else begin
      $display("cmap_segment_glyph_lookup regression: fail");
    end
    $finish;
  end

endmodule
